// ===== rtl/core/wfr_pkg.sv =====
`default_nettype none

package wfr_pkg;

  // Width of the internal frame counter; the frame number port shows all of its bits.
  localparam int unsigned IdWidth     = 16;
  localparam int unsigned FrameNumW   = 16;
  localparam int unsigned LenWidth    = 32;

  localparam logic [7:0] FinMask      = 8'h80;
  localparam logic [7:0] CtlMask      = 8'h08;
  localparam logic [6:0] Len16Code    = 7'd126;
  localparam logic [3:0] OpClose      = 4'h8;
  localparam logic [3:0] OpPing       = 4'h9;
  localparam logic [3:0] XlenBytes16  = 4'd2;
  localparam logic [3:0] XlenBytes64  = 4'd8;
  // Extended length bytes above this count must be zero.
  localparam logic [3:0] XlenTopLimit = 4'd4;

  typedef enum logic [2:0] {
    KindHeader  = 3'd0,
    KindPayload = 3'd1,
    KindEmpty   = 3'd2,
    KindPing    = 3'd3,
    KindClose   = 3'd4,
    KindError   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrMasked  = 2'd1,
    ErrLength  = 2'd2,
    ErrControl = 2'd3
  } err_e;

  typedef enum logic [4:0] {
    PhHdr0 = 5'b00001,
    PhHdr1 = 5'b00010,
    PhXlen = 5'b00100,
    PhData = 5'b01000,
    PhErr  = 5'b10000
  } phase_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           payload_byte;
    logic [FrameNumW-1:0] frame_number;
    logic [3:0]           hdr_opcode;
    logic                 frame_final;
    logic                 payload_end;
    err_e                 error_code;
  } wfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/websocket_frame_receiver_core.sv =====
`default_nettype none

// WebSocket frame receiver: takes one stream byte per beat and returns exactly
// one result beat per byte, in the order the bytes are accepted. A byte can be taken
// in every cycle; the parser state updates on each accepted byte, and the result
// goes into a two-entry output buffer, so one more byte is taken while a result
// waits and the input stalls only once both entries are occupied. Errors are
// sticky: after one, every byte reports the error until reset.
module websocket_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      frame_number_o,
  output logic [3:0]       hdr_opcode_o,
  output logic             frame_final_o,
  output logic             payload_end_o,
  output logic [1:0]       error_code_o
);
  import wfr_pkg::*;

  logic        accept;
  logic        buf_full;
  wfr_result_t result;
  wfr_result_t out_data;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  wfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .result_o    (result)
  );

  wfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_data)
  );

  assign kind_o         = out_data.kind;
  assign payload_byte_o = out_data.payload_byte;
  assign frame_number_o = out_data.frame_number;
  assign hdr_opcode_o   = out_data.hdr_opcode;
  assign frame_final_o  = out_data.frame_final;
  assign payload_end_o  = out_data.payload_end;
  assign error_code_o   = out_data.error_code;

  a_err_code_with_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KindError) == (error_code_o != ErrNone)))
    else $error("error code and error kind disagree");

  a_payload_only_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KindPayload) |-> (payload_byte_o == 8'h00))
    else $error("payload byte set on a non-payload beat");

  a_stall_only_after_out_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

  a_error_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && kind_o == KindError) ##1 out_valid_o
      |-> (kind_o == KindError))
    else $error("error state left before reset");

endmodule

`default_nettype wire

// ===== rtl/core/wfr_parser.sv =====
`default_nettype none

module wfr_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_byte_i,
  output wfr_pkg::wfr_result_t    result_o
);
  import wfr_pkg::*;

  phase_e               phase_q, phase_d;
  logic [7:0]           first_header_q, first_header_d;
  logic [3:0]           left_q, left_d;
  logic [LenWidth-1:0]  frame_length_q, frame_length_d;
  logic [LenWidth-1:0]  bytes_done_q, bytes_done_d;
  logic [IdWidth-1:0]   counter_q, counter_d;
  err_e                 sticky_q, sticky_d;

  logic  hdr_done;
  logic  end_frame;
  logic  is_ctl;
  logic  last;
  kind_e ctl_kind;
  kind_e kind;
  logic [7:0] pbyte;
  logic  pend;

  assign is_ctl   = (first_header_q & CtlMask) != 8'h00;
  assign ctl_kind = (first_header_q[3:0] == OpPing) ? KindPing : KindClose;

  always_comb begin
    phase_d        = phase_q;
    first_header_d = first_header_q;
    left_d         = left_q;
    frame_length_d = frame_length_q;
    bytes_done_d   = bytes_done_q;
    counter_d      = counter_q;
    sticky_d       = sticky_q;
    hdr_done       = 1'b0;
    end_frame      = 1'b0;
    last           = 1'b0;
    kind           = KindHeader;
    pbyte          = 8'h00;
    pend           = 1'b0;

    case (phase_q)
      PhErr: begin
        kind = KindError;
      end
      PhHdr1: begin
        if (data_byte_i[7]) begin
          sticky_d = ErrMasked;
          phase_d  = PhErr;
          kind     = KindError;
        end else if (data_byte_i[6:0] < Len16Code) begin
          frame_length_d = LenWidth'(data_byte_i[6:0]);
          hdr_done       = 1'b1;
        end else begin
          frame_length_d = '0;
          left_d         = (data_byte_i[6:0] == Len16Code) ? XlenBytes16 : XlenBytes64;
          phase_d        = PhXlen;
        end
      end
      PhXlen: begin
        if (left_q > XlenTopLimit && data_byte_i != 8'h00) begin
          sticky_d = ErrLength;
          phase_d  = PhErr;
          kind     = KindError;
        end else begin
          frame_length_d = {frame_length_q[LenWidth-9:0], data_byte_i};
          left_d         = left_q - 4'd1;
          hdr_done       = (left_d == 4'd0);
        end
      end
      PhData: begin
        bytes_done_d = bytes_done_q + 1'b1;
        last         = (bytes_done_d == frame_length_q);
        if (is_ctl) begin
          kind = last ? ctl_kind : KindHeader;
        end else begin
          kind  = KindPayload;
          pbyte = data_byte_i;
        end
        if (last) begin
          pend      = 1'b1;
          end_frame = 1'b1;
        end
      end
      default: begin
        first_header_d = data_byte_i;
        phase_d        = PhHdr1;
      end
    endcase

    // Header complete: reject unknown control opcodes, then either start the
    // payload or close out a frame that has no payload at all.
    if (hdr_done) begin
      if (is_ctl && first_header_q[3:0] != OpClose && first_header_q[3:0] != OpPing) begin
        sticky_d = ErrControl;
        phase_d  = PhErr;
        kind     = KindError;
      end else begin
        bytes_done_d = '0;
        if (frame_length_d == '0) begin
          kind      = is_ctl ? ctl_kind : KindEmpty;
          pend      = 1'b1;
          end_frame = 1'b1;
        end else begin
          phase_d = PhData;
        end
      end
    end

    if (end_frame) begin
      phase_d = PhHdr0;
      if ((first_header_q & FinMask) != 8'h00 && !is_ctl) begin
        counter_d = counter_q + 1'b1;
      end
    end
  end

  always_comb begin
    result_o.kind         = kind;
    result_o.payload_byte = pbyte;
    result_o.frame_number = FrameNumW'(counter_q);
    result_o.hdr_opcode   = first_header_d[3:0];
    result_o.frame_final  = first_header_d[7];
    result_o.payload_end  = pend;
    result_o.error_code   = (kind == KindError) ? sticky_d : ErrNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHdr0;
      first_header_q <= '0;
      left_q         <= '0;
      frame_length_q <= '0;
      bytes_done_q   <= '0;
      counter_q      <= '0;
      sticky_q       <= ErrNone;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      first_header_q <= first_header_d;
      left_q         <= left_d;
      frame_length_q <= frame_length_d;
      bytes_done_q   <= bytes_done_d;
      counter_q      <= counter_d;
      sticky_q       <= sticky_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wfr_out_buf.sv =====
`default_nettype none

module wfr_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire wfr_pkg::wfr_result_t push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output wfr_pkg::wfr_result_t data_o
);
  import wfr_pkg::*;

  logic        main_valid_q;
  logic        skid_valid_q;
  wfr_result_t main_q;
  wfr_result_t skid_q;
  logic        pop;

  assign pop     = main_valid_q && !stall_i;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  // The skid entry only fills when the main entry is stalled, so a full
  // flag taken from a register keeps the input side free of stall_i.
  assign full_o  = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/websocket_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps

module websocket_frame_receiver_core_tb;
  import wfr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam logic [7:0]  MASK_FLAG      = 8'h80;
  localparam logic [7:0]  RSV_BITS       = 8'h70;
  localparam logic [6:0]  LEN64_CODE     = 7'd127;
  localparam logic [3:0]  OP_CONT        = 4'h0;
  localparam logic [3:0]  OP_TEXT        = 4'h1;
  localparam logic [3:0]  OP_BINARY      = 4'h2;
  localparam logic [3:0]  OP_DATA_LAST   = 4'h7;
  localparam logic [3:0]  OP_MAX         = 4'hF;

  typedef enum int unsigned {
    LenShort,
    LenExt16,
    LenExt64
  } len_form_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_number;
  logic [3:0]  hdr_opcode;
  logic        frame_final;
  logic        payload_end;
  logic [1:0]  error_code;

  // Predictor state for the deframer.
  phase_e             rx_phase       = PhHdr0;
  logic [7:0]         rx_header      = '0;
  logic [3:0]         len_bytes_left = '0;
  logic [31:0]        payload_len    = '0;
  logic [31:0]        payload_count  = '0;
  logic [IdWidth-1:0] frames_done    = '0;
  err_e               rx_error       = ErrNone;

  wfr_result_t event_q[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_left     = 0;
  bit          send_idle_on   = 1'b1;
  bit          stall_on       = 1'b1;

  websocket_frame_receiver_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .payload_byte_o (payload_byte),
    .frame_number_o (frame_number),
    .hdr_opcode_o   (hdr_opcode),
    .frame_final_o  (frame_final),
    .payload_end_o  (payload_end),
    .error_code_o   (error_code)
  );

  always #5 clk = ~clk;

  function automatic logic is_ctl();
    return (rx_header & CtlMask) != 0;
  endfunction

  function automatic kind_e ctl_event();
    if (rx_header[3:0] == OpPing) return KindPing;
    return KindClose;
  endfunction

  // Only a final data frame advances the frame number.
  function automatic void close_frame();
    if ((rx_header & FinMask) != 0 && !is_ctl()) frames_done = frames_done + 1'b1;
    rx_phase = PhHdr0;
  endfunction

  function automatic kind_e header_complete(output logic ends);
    ends = 1'b0;
    if (is_ctl() && rx_header[3:0] != OpClose && rx_header[3:0] != OpPing) begin
      rx_error = ErrControl;
      rx_phase = PhErr;
      return KindError;
    end
    payload_count = '0;
    if (payload_len == 0) begin
      ends = 1'b1;
      close_frame();
      if (is_ctl()) return ctl_event();
      return KindEmpty;
    end
    rx_phase = PhData;
    return KindHeader;
  endfunction

  function automatic wfr_result_t parse_byte(input logic [7:0] b);
    wfr_result_t r;
    logic        ends;
    logic        last;
    r = '0;
    ends = 1'b0;
    r.kind = KindHeader;
    r.frame_number = frames_done[FrameNumW-1:0];
    case (rx_phase)
      PhErr: r.kind = KindError;
      PhHdr1: begin
        if ((b & MASK_FLAG) != 0) begin
          rx_error = ErrMasked;
          rx_phase = PhErr;
          r.kind = KindError;
        end else if (b[6:0] < Len16Code) begin
          payload_len = 32'(b[6:0]);
          r.kind = header_complete(ends);
        end else begin
          payload_len = '0;
          len_bytes_left = (b[6:0] == Len16Code) ? XlenBytes16 : XlenBytes64;
          rx_phase = PhXlen;
        end
      end
      PhXlen: begin
        // The upper half of a 64-bit length must be all zero bytes.
        if (len_bytes_left > XlenTopLimit && b != 0) begin
          rx_error = ErrLength;
          rx_phase = PhErr;
          r.kind = KindError;
        end else begin
          payload_len = {payload_len[23:0], b};
          len_bytes_left = len_bytes_left - 1'b1;
          if (len_bytes_left == 0) r.kind = header_complete(ends);
        end
      end
      PhData: begin
        payload_count = payload_count + 1;
        last = (payload_count == payload_len);
        if (is_ctl()) begin
          if (last) r.kind = ctl_event();
        end else begin
          r.kind = KindPayload;
          r.payload_byte = b;
        end
        if (last) begin
          ends = 1'b1;
          close_frame();
        end
      end
      default: begin
        rx_header = b;
        rx_phase = PhHdr1;
      end
    endcase
    r.hdr_opcode = rx_header[3:0];
    r.frame_final = rx_header[7];
    r.payload_end = ends;
    if (r.kind == KindError) r.error_code = rx_error;
    else r.error_code = ErrNone;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (send_idle_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    event_q.push_back(parse_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] first, input logic [31:0] len,
                            input len_form_e form);
    int i;
    send_byte(first);
    case (form)
      LenShort: send_byte({1'b0, len[6:0]});
      LenExt16: begin
        send_byte({1'b0, Len16Code});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'b0, LEN64_CODE});
        repeat (4) send_byte(8'h00);
        for (i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [3:0]  opcode;
    logic [31:0] len;
    len_form_e   form;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) opcode = 4'($urandom_range(OP_CONT, OP_DATA_LAST));
    else if (pick < 8) opcode = OpPing;
    else opcode = OpClose;
    pick = $urandom_range(0, 19);
    form = LenShort;
    if (pick < 14) begin
      len = $urandom_range(0, 12);
    end else if (pick == 14) begin
      len = $urandom_range(13, 125);
    end else if (pick < 18) begin
      form = LenExt16;
      len = (pick == 17) ? $urandom_range(256, 300) : $urandom_range(0, 40);
    end else begin
      form = LenExt64;
      len = $urandom_range(0, 40);
    end
    send_frame({1'($urandom), 3'($urandom), opcode}, len, form);
  endtask

  task automatic test_directed();
    // Final text frame with reserved bits set and no payload.
    send_byte(FinMask | RSV_BITS | {4'h0, OP_TEXT});
    send_byte(8'h00);
    // Empty ping.
    send_byte(FinMask | {4'h0, OpPing});
    send_byte(8'h00);
    // Close without FIN and a 16-bit length of one: its only byte reports the close.
    send_byte({4'h0, OpClose});
    send_byte({1'b0, Len16Code});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    // Non-final continuation with a 64-bit length of two.
    send_byte({4'h0, OP_CONT});
    send_byte({1'b0, LEN64_CODE});
    repeat (7) send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    // Final binary frame with one byte.
    send_byte(FinMask | {4'h0, OP_BINARY});
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  task automatic test_random_frames();
    int unsigned n;
    n = 0;
    while (bytes_sent < 900) begin
      // Switch idling and output stalls on and off now and then, so some stretches run at full rate.
      if (n % 8 == 0) begin
        send_idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      send_random_frame();
      n++;
    end
    send_idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (3) send_random_frame();
      in_valid = 1'b0;
      while (event_q.size() != 0) @(negedge clk);
    end
  endtask

  task automatic test_full_rate();
    send_idle_on = 1'b0;
    stall_on = 1'b0;
    while (bytes_sent < 1450) send_random_frame();
  endtask

  task automatic test_sticky_error();
    err_e which;
    which = err_e'($urandom_range(ErrMasked, ErrControl));
    case (which)
      ErrMasked: begin
        send_byte({1'($urandom), 3'($urandom), 4'($urandom_range(OP_CONT, OP_DATA_LAST))});
        send_byte(MASK_FLAG | 8'($urandom_range(0, 127)));
      end
      ErrLength: begin
        send_byte({1'($urandom), 3'($urandom), 4'($urandom_range(OP_CONT, OP_DATA_LAST))});
        send_byte({1'b0, LEN64_CODE});
        repeat ($urandom_range(0, 3)) send_byte(8'h00);
        send_byte(8'($urandom_range(1, 255)));
      end
      default: begin
        send_byte({1'($urandom), 3'($urandom), 4'($urandom_range(OpPing + 1, OP_MAX))});
        send_byte(8'($urandom_range(0, 125)));
      end
    endcase
    // Everything after the error must keep reporting it.
    repeat (40) send_byte(8'($urandom));
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    wfr_result_t want;
    if (out_valid && !out_stall) begin
      if (event_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = event_q.pop_front();
        check_field("kind", 16'(kind), 16'(want.kind));
        check_field("payload_byte", 16'(payload_byte), 16'(want.payload_byte));
        check_field("frame_number", frame_number, want.frame_number);
        check_field("hdr_opcode", 16'(hdr_opcode), 16'(want.hdr_opcode));
        check_field("frame_final", 16'(frame_final), 16'(want.frame_final));
        check_field("payload_end", 16'(payload_end), 16'(want.payload_end));
        check_field("error_code", 16'(error_code), 16'(want.error_code));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("websocket_frame_receiver_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random_frames();
    test_drain_pause();
    test_full_rate();
    test_sticky_error();
    in_valid = 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("websocket_frame_receiver_core_tb: done, clean");
    end else begin
      $display("websocket_frame_receiver_core_tb: done, errors");
    end
    $finish;
  end

endmodule
